>>> hdl/lba_pkg.sv
// Shared types and constants for the linked block allocator.
// No dependencies; imported by lba_core and linked_block_allocator_unit.
`default_nettype none

package lba_pkg;

  localparam int BLOCKS_DEF  = 64;
  localparam int FILES_DEF   = 16;
  localparam int MAX_RESULTS = 64;

  localparam int KIND_W   = 1;
  localparam int SIZE_W   = 7;
  localparam int FILE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int BLOCK_W  = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 1'b0,
    KIND_WALK   = 1'b1
  } lba_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DIR_FULL  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_ZERO_SIZE = 3'd3,
    ST_NO_FILE   = 3'd4
  } lba_status_e;

  typedef struct packed {
    lba_kind_e          kind;
    logic [SIZE_W-1:0]  size;
    logic [FILE_W-1:0]  file_index;
  } lba_in_t;

  typedef struct packed {
    lba_status_e        status;
    logic [FILE_W-1:0]  file_index_res;
    logic [BLOCK_W-1:0] block;
    logic [BLOCK_W-1:0] end_block;
    logic               last;
  } lba_out_t;

endpackage

`default_nettype wire

>>> hdl/linked_block_allocator_unit.sv
// Linked block allocator top level: sequencer plus block table and directory RAMs.
// A create fills its chain in the block table, then writes the directory and emits its result;
// a walk reads the directory, then gives one chain word per cycle while the output flows.
// Create uses the table write port and walk uses the table read port.
// Reset: all blocks free, no files; RAM contents are not cleared.
// Depends on lba_pkg, lba_ram and lba_core.
`default_nettype none

module linked_block_allocator_unit #(
  parameter int BLOCKS = lba_pkg::BLOCKS_DEF,
  parameter int FILES  = lba_pkg::FILES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire lba_pkg::lba_in_t  in_word_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output lba_pkg::lba_out_t      out_word_o,
  input  wire logic              out_stall_i
);

  import lba_pkg::*;

  localparam int BW  = $clog2(BLOCKS);
  localparam int FIW = (FILES > 1) ? $clog2(FILES) : 1;

  logic          tbl_we;
  logic [BW-1:0] tbl_waddr;
  logic [BW:0]   tbl_wdata;
  logic          tbl_re;
  logic [BW-1:0] tbl_raddr;
  logic [BW:0]   tbl_rdata;
  logic            dir_we;
  logic [FIW-1:0]  dir_waddr;
  logic [2*BW-1:0] dir_wdata;
  logic            dir_re;
  logic [FIW-1:0]  dir_raddr;
  logic [2*BW-1:0] dir_rdata;

  lba_core #(
    .BLOCKS (BLOCKS),
    .FILES  (FILES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_re_o    (tbl_re),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata),
    .dir_we_o    (dir_we),
    .dir_waddr_o (dir_waddr),
    .dir_wdata_o (dir_wdata),
    .dir_re_o    (dir_re),
    .dir_raddr_o (dir_raddr),
    .dir_rdata_i (dir_rdata)
  );

  // entry: {end of chain, next block}
  lba_ram #(
    .WIDTH (BW + 1),
    .DEPTH (BLOCKS)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // entry: {start block, end block}
  lba_ram #(
    .WIDTH (2 * BW),
    .DEPTH (FILES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (dir_re),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  a_fill_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> in_stall_o)
    else $error("block table written while input is open");

  a_dir_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_we |=> !dir_we)
    else $error("directory written on two cycles in a row");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accepting a word");

  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_re |-> !tbl_we)
    else $error("block table read and written in the same cycle");

endmodule

`default_nettype wire

>>> hdl/lba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the block table and the directory.
`default_nettype none

module lba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/lba_core.sv
// Allocator sequencer: fill pointer incrementer and compare, walk counter
// and stop compare, plus the output word register. Uses lba_pkg.
`default_nettype none

module lba_core #(
  parameter int BLOCKS = lba_pkg::BLOCKS_DEF,
  parameter int FILES  = lba_pkg::FILES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire lba_pkg::lba_in_t    in_word_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  output lba_pkg::lba_out_t        out_word_o,
  input  wire logic                out_stall_i,
  output logic                     tbl_we_o,
  output logic [$clog2(BLOCKS)-1:0] tbl_waddr_o,
  output logic [$clog2(BLOCKS):0]  tbl_wdata_o,
  output logic                     tbl_re_o,
  output logic [$clog2(BLOCKS)-1:0] tbl_raddr_o,
  input  wire logic [$clog2(BLOCKS):0] tbl_rdata_i,
  output logic                     dir_we_o,
  output logic [((FILES > 1) ? $clog2(FILES) : 1)-1:0] dir_waddr_o,
  output logic [2*$clog2(BLOCKS)-1:0] dir_wdata_o,
  output logic                     dir_re_o,
  output logic [((FILES > 1) ? $clog2(FILES) : 1)-1:0] dir_raddr_o,
  input  wire logic [2*$clog2(BLOCKS)-1:0] dir_rdata_i
);

  import lba_pkg::*;

  localparam int BW    = $clog2(BLOCKS);
  localparam int CW    = $clog2(BLOCKS + 1);
  localparam int FIW   = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int FUW   = $clog2(FILES + 1);
  localparam int CMPF  = (FILE_W > FUW) ? FILE_W : FUW;
  localparam int SUMW  = ((SIZE_W > CW) ? SIZE_W : CW) + 1;
  localparam int LIMIT = (MAX_RESULTS < BLOCKS) ? MAX_RESULTS : BLOCKS;
  localparam int CNTW  = $clog2(LIMIT + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FILL = 5'b00010,
    S_DIR  = 5'b00100,
    S_WALK = 5'b01000,
    S_EMIT = 5'b10000
  } lba_state_e;

  lba_state_e        state_q, state_d;
  logic [CW-1:0]     alloc_q, alloc_d;
  logic [FUW-1:0]    files_q, files_d;
  logic [BW-1:0]     ptr_q, ptr_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic [BW-1:0]     blk_q, blk_d;
  logic [BW-1:0]     endb_q, endb_d;
  logic [FILE_W-1:0] fi_q, fi_d;
  lba_out_t          res_q, res_d;
  logic              out_valid_q, out_valid_d;
  lba_out_t          out_q, out_d;

  logic              slot_free;
  logic              load;
  logic [CW-1:0]     ptr_inc;
  logic [CNTW-1:0]   cnt_inc;
  logic              fill_last;
  logic              stop;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign ptr_inc    = CW'(ptr_q) + CW'(1);
  assign cnt_inc    = cnt_q + CNTW'(1);
  assign fill_last  = (rem_q == SIZE_W'(1));
  assign stop       = tbl_rdata_i[BW] || (CW'(blk_q) >= alloc_q) ||
                      (cnt_inc >= CNTW'(LIMIT));

  always_comb begin
    state_d     = state_q;
    alloc_d     = alloc_q;
    files_d     = files_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    blk_d       = blk_q;
    endb_d      = endb_q;
    fi_d        = fi_q;
    res_d       = res_q;
    load        = 1'b0;
    out_d       = out_q;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = ptr_q;
    tbl_wdata_o = {fill_last, fill_last ? BW'(0) : BW'(ptr_inc)};
    tbl_re_o    = 1'b0;
    tbl_raddr_o = tbl_rdata_i[BW-1:0];
    dir_we_o    = 1'b0;
    dir_waddr_o = FIW'(files_q);
    dir_wdata_o = {BW'(alloc_q), ptr_q};
    dir_re_o    = 1'b0;
    dir_raddr_o = FIW'(in_word_i.file_index);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          fi_d                 = in_word_i.file_index;
          res_d                = '0;
          res_d.last           = 1'b1;
          state_d              = S_EMIT;
          if (in_word_i.kind == KIND_CREATE) begin
            if (files_q >= FUW'(FILES)) begin
              res_d.status = ST_DIR_FULL;
            end else if (in_word_i.size == '0) begin
              res_d.status = ST_ZERO_SIZE;
            end else if ((SUMW'(in_word_i.size) + SUMW'(alloc_q)) > SUMW'(BLOCKS)) begin
              res_d.status = ST_NO_SPACE;
            end else begin
              ptr_d   = BW'(alloc_q);
              rem_d   = in_word_i.size;
              state_d = S_FILL;
            end
          end else begin
            if (CMPF'(in_word_i.file_index) >= CMPF'(files_q)) begin
              res_d.status         = ST_NO_FILE;
              res_d.file_index_res = in_word_i.file_index;
            end else begin
              dir_re_o = 1'b1;
              state_d  = S_DIR;
            end
          end
        end
      end
      S_FILL: begin
        tbl_we_o = 1'b1;
        ptr_d    = BW'(ptr_inc);
        rem_d    = rem_q - SIZE_W'(1);
        if (fill_last) begin
          dir_we_o             = 1'b1;
          alloc_d              = ptr_inc;
          files_d              = files_q + FUW'(1);
          res_d.status         = ST_OK;
          res_d.file_index_res = FILE_W'(files_q);
          res_d.block          = BLOCK_W'(alloc_q);
          res_d.end_block      = BLOCK_W'(ptr_q);
          res_d.last           = 1'b1;
          state_d              = S_EMIT;
        end
      end
      S_DIR: begin
        blk_d       = dir_rdata_i[2*BW-1:BW];
        endb_d      = dir_rdata_i[BW-1:0];
        tbl_re_o    = 1'b1;
        tbl_raddr_o = dir_rdata_i[2*BW-1:BW];
        cnt_d       = '0;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (slot_free) begin
          load                 = 1'b1;
          out_d.status         = ST_OK;
          out_d.file_index_res = fi_q;
          out_d.block          = BLOCK_W'(blk_q);
          out_d.end_block      = BLOCK_W'(endb_q);
          out_d.last           = stop;
          cnt_d                = cnt_inc;
          if (stop) begin
            state_d = S_IDLE;
          end else begin
            blk_d    = tbl_rdata_i[BW-1:0];
            tbl_re_o = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load    = 1'b1;
          out_d   = res_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alloc_q     <= '0;
      files_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      alloc_q     <= alloc_d;
      files_q     <= files_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    blk_q  <= blk_d;
    endb_q <= endb_d;
    fi_q   <= fi_d;
    res_q  <= res_d;
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
